// ===== sv/wrrca_pkg.sv =====
package wrrca_pkg;

  localparam int NUM_INPUTS  = 8;
  localparam int NUM_OUTPUTS = 4;

  localparam int IN_IDX_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int PORT_W   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int CNT_W    = $clog2(NUM_OUTPUTS + 1);
  localparam int RANK_W   = $clog2(NUM_INPUTS + NUM_OUTPUTS + 1);
  localparam int POS_EXT_W = IN_IDX_W + 1;

  localparam int IN_FIELDS_W  = 2 * NUM_INPUTS + NUM_OUTPUTS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = NUM_OUTPUTS + NUM_OUTPUTS * IN_IDX_W + NUM_INPUTS
                                + NUM_OUTPUTS + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [IN_IDX_W-1:0] in_idx_t;
  typedef logic [PORT_W-1:0]   port_t;

  // per-input lane finding
  typedef struct packed {
    logic    search;   // wants the lowest free, unreserved output
    logic    resv_ok;  // reserved output is free, granted
    in_idx_t pos;      // place in round-robin order
    port_t   port;     // reserved output
  } lane_t;

  typedef struct packed {
    logic  granted;
    port_t dst;
  } lane_grant_t;

endpackage

// ===== sv/wormhole_round_robin_crossbar_arbiter_top.sv =====
// Channel  | Dir | Signals                   | Contents
// s_axis   | in  | tvalid tready tdata[23:0] | request transfer per clock
// m_axis   | out | tvalid tready tdata[31:0] | grant result per request
// cfg      | in  | valid ready data[0]       | wormhole_enable
//
// One request per cycle while s_axis_tready is high; its result appears in the output register the next cycle.
// All inputs are evaluated in one lane each; one merge stage assigns outputs.
// Reset clears busy, seen and reservation state; last grant resets to the top input.
// s_axis_tready drops only while a result waits and m_axis_tready is low.
module wormhole_round_robin_crossbar_arbiter_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // request_valid, request_end_of_packet, output_consumed
  input  logic [wrrca_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // grant_mask, grant_sources, input_ack, busy_outputs, active_count
  output logic [wrrca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i
);

  localparam int N = wrrca_pkg::NUM_INPUTS;
  localparam int M = wrrca_pkg::NUM_OUTPUTS;

  logic                      worm_q;
  logic [M-1:0]              busy_q, busy_d, busy_free;
  wrrca_pkg::in_idx_t        src_q [M];
  logic [N-1:0]              seen_q, seen_d, seen_eff;
  logic [N-1:0]              held_q, held_d;
  wrrca_pkg::port_t          port_q [N];
  logic [M-1:0]              rsv_q, rsv_d;
  wrrca_pkg::in_idx_t        last_q, last_d;
  logic [wrrca_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      out_vld_q;
  logic [wrrca_pkg::OUT_DATA_W-1:0] out_q, out_d;

  logic [N-1:0]              req_valid, req_eop, ack;
  logic [M-1:0]              consumed, free_pool;
  logic                      accept;

  wrrca_pkg::lane_t          lanes  [N];
  wrrca_pkg::lane_grant_t    grants [N];
  logic [M-1:0]              out_grant;
  wrrca_pkg::in_idx_t        out_src [M];
  logic                      last_vld;
  wrrca_pkg::in_idx_t        last_idx;
  logic [M*wrrca_pkg::IN_IDX_W-1:0] src_packed;

  assign req_valid = s_axis_tdata[N-1:0];
  assign req_eop   = s_axis_tdata[2*N-1:N];
  assign consumed  = s_axis_tdata[2*N+M-1:2*N];

  assign s_axis_tready = ~out_vld_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    ack = '0;
    for (int j = 0; j < M; j++) begin
      if (busy_q[j] && consumed[j]) begin
        ack[src_q[j]] = 1'b1;
      end
    end
  end

  assign busy_free = busy_q & ~consumed;
  assign seen_eff  = seen_q & ~ack;
  assign free_pool = ~busy_free & ~(rsv_q & {M{worm_q}});

  for (genvar i = 0; i < N; i++) begin : g_lane
    wrrca_lane u_lane (
      .idx_i          (wrrca_pkg::IN_IDX_W'(i)),
      .last_granted_i (last_q),
      .valid_i        (req_valid[i]),
      .seen_i         (seen_eff[i]),
      .worm_i         (worm_q),
      .held_i         (held_q[i]),
      .port_i         (port_q[i]),
      .busy_i         (busy_free),
      .lane_o         (lanes[i])
    );
  end

  wrrca_merge u_merge (
    .lanes_i     (lanes),
    .free_i      (free_pool),
    .grants_o    (grants),
    .out_grant_o (out_grant),
    .out_src_o   (out_src),
    .last_vld_o  (last_vld),
    .last_idx_o  (last_idx)
  );

  always_comb begin
    busy_d = busy_free | out_grant;
    cnt_d  = '0;
    for (int j = 0; j < M; j++) begin
      cnt_d = cnt_d + wrrca_pkg::CNT_W'(busy_d[j]);
    end
    seen_d = seen_eff;
    held_d = held_q;
    for (int i = 0; i < N; i++) begin
      if (grants[i].granted) begin
        seen_d[i] = 1'b1;
        if (worm_q) begin
          held_d[i] = ~req_eop[i];
        end
      end
    end
    rsv_d      = rsv_q;
    src_packed = '0;
    for (int j = 0; j < M; j++) begin
      if (out_grant[j]) begin
        src_packed[j*wrrca_pkg::IN_IDX_W +: wrrca_pkg::IN_IDX_W] = out_src[j];
        if (worm_q) begin
          rsv_d[j] = ~req_eop[out_src[j]];
        end
      end
    end
    last_d = last_vld ? last_idx : last_q;
    out_d  = wrrca_pkg::OUT_DATA_W'({cnt_d, busy_d, ack, src_packed, out_grant});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worm_q    <= 1'b0;
      busy_q    <= '0;
      seen_q    <= '0;
      held_q    <= '0;
      rsv_q     <= '0;
      last_q    <= wrrca_pkg::IN_IDX_W'(N - 1);
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        worm_q <= cfg_data_i;
      end
      if (accept) begin
        busy_q <= busy_d;
        seen_q <= seen_d;
        held_q <= held_d;
        rsv_q  <= rsv_d;
        last_q <= last_d;
        cnt_q  <= cnt_d;
      end
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
      for (int j = 0; j < M; j++) begin
        if (out_grant[j]) begin
          src_q[j] <= out_src[j];
        end
      end
      for (int i = 0; i < N; i++) begin
        if (grants[i].granted && worm_q && !req_eop[i]) begin
          port_q[i] <= grants[i].dst;
        end
      end
    end
  end

  a_cnt_matches_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == wrrca_pkg::CNT_W'($countones(busy_q)))
    else $error("transfer count differs from busy outputs");

  a_grant_is_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q[M-1:0] & ~busy_q) == '0))
    else $error("granted output not marked busy");

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_vld_q)
    else $error("accepted request produced no result");

  a_grant_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ($countones(out_grant) <= $countones(req_valid & ~seen_eff)))
    else $error("more grants than eligible requests");

endmodule

// ===== sv/wrrca_lane.sv =====
module wrrca_lane (
  input  wrrca_pkg::in_idx_t          idx_i,
  input  wrrca_pkg::in_idx_t          last_granted_i,
  input  logic                        valid_i,
  input  logic                        seen_i,
  input  logic                        worm_i,
  input  logic                        held_i,
  input  wrrca_pkg::port_t            port_i,
  input  logic [wrrca_pkg::NUM_OUTPUTS-1:0] busy_i,
  output wrrca_pkg::lane_t            lane_o
);

  logic                                  req;
  logic                                  use_resv;
  logic [wrrca_pkg::POS_EXT_W-1:0]       pos_raw;

  assign req      = valid_i & ~seen_i;
  assign use_resv = worm_i & held_i;

  // (idx - last_granted - 1) mod NUM_INPUTS
  assign pos_raw = wrrca_pkg::POS_EXT_W'(idx_i)
                 + wrrca_pkg::POS_EXT_W'(wrrca_pkg::NUM_INPUTS - 1)
                 - wrrca_pkg::POS_EXT_W'(last_granted_i);

  always_comb begin
    lane_o.search  = req & ~use_resv;
    lane_o.resv_ok = req & use_resv & ~busy_i[port_i];
    lane_o.port    = port_i;
    if (pos_raw >= wrrca_pkg::POS_EXT_W'(wrrca_pkg::NUM_INPUTS)) begin
      lane_o.pos = wrrca_pkg::IN_IDX_W'(pos_raw - wrrca_pkg::POS_EXT_W'(wrrca_pkg::NUM_INPUTS));
    end else begin
      lane_o.pos = wrrca_pkg::IN_IDX_W'(pos_raw);
    end
  end

endmodule

// ===== sv/wrrca_merge.sv =====
module wrrca_merge (
  input  wrrca_pkg::lane_t                  lanes_i [wrrca_pkg::NUM_INPUTS],
  input  logic [wrrca_pkg::NUM_OUTPUTS-1:0] free_i,
  output wrrca_pkg::lane_grant_t            grants_o [wrrca_pkg::NUM_INPUTS],
  output logic [wrrca_pkg::NUM_OUTPUTS-1:0] out_grant_o,
  output wrrca_pkg::in_idx_t                out_src_o [wrrca_pkg::NUM_OUTPUTS],
  output logic                              last_vld_o,
  output wrrca_pkg::in_idx_t                last_idx_o
);

  logic [wrrca_pkg::RANK_W-1:0] frank [wrrca_pkg::NUM_OUTPUTS];
  logic [wrrca_pkg::RANK_W-1:0] rank  [wrrca_pkg::NUM_INPUTS];
  wrrca_pkg::lane_grant_t       gnt   [wrrca_pkg::NUM_INPUTS];
  logic                         is_last [wrrca_pkg::NUM_INPUTS];

  always_comb begin
    // rank of each free output among the free ones
    for (int j = 0; j < wrrca_pkg::NUM_OUTPUTS; j++) begin
      frank[j] = '0;
      for (int k = 0; k < j; k++) begin
        frank[j] = frank[j] + wrrca_pkg::RANK_W'(free_i[k]);
      end
    end

    // searching lanes ahead in round-robin order
    for (int i = 0; i < wrrca_pkg::NUM_INPUTS; i++) begin
      rank[i] = '0;
      for (int k = 0; k < wrrca_pkg::NUM_INPUTS; k++) begin
        if (lanes_i[k].search && (lanes_i[k].pos < lanes_i[i].pos)) begin
          rank[i] = rank[i] + wrrca_pkg::RANK_W'(1);
        end
      end
    end

    for (int i = 0; i < wrrca_pkg::NUM_INPUTS; i++) begin
      gnt[i].granted = lanes_i[i].resv_ok;
      gnt[i].dst     = lanes_i[i].port;
      if (lanes_i[i].search) begin
        for (int j = 0; j < wrrca_pkg::NUM_OUTPUTS; j++) begin
          if (free_i[j] && (frank[j] == rank[i])) begin
            gnt[i].granted = 1'b1;
            gnt[i].dst     = wrrca_pkg::PORT_W'(j);
          end
        end
      end
    end

    for (int j = 0; j < wrrca_pkg::NUM_OUTPUTS; j++) begin
      out_grant_o[j] = 1'b0;
      out_src_o[j]   = '0;
      for (int i = 0; i < wrrca_pkg::NUM_INPUTS; i++) begin
        if (gnt[i].granted && (gnt[i].dst == wrrca_pkg::PORT_W'(j))) begin
          out_grant_o[j] = 1'b1;
          out_src_o[j]   = wrrca_pkg::IN_IDX_W'(i);
        end
      end
    end

    // last grant in scan order
    last_vld_o = 1'b0;
    last_idx_o = '0;
    for (int i = 0; i < wrrca_pkg::NUM_INPUTS; i++) begin
      is_last[i] = gnt[i].granted;
      for (int k = 0; k < wrrca_pkg::NUM_INPUTS; k++) begin
        if (gnt[k].granted && (lanes_i[k].pos > lanes_i[i].pos)) begin
          is_last[i] = 1'b0;
        end
      end
      if (is_last[i]) begin
        last_vld_o = 1'b1;
        last_idx_o = wrrca_pkg::IN_IDX_W'(i);
      end
    end

    for (int i = 0; i < wrrca_pkg::NUM_INPUTS; i++) begin
      grants_o[i] = gnt[i];
    end
  end

endmodule

// ===== tb/sv/tb_wormhole_round_robin_crossbar_arbiter_top.sv =====
`timescale 1ns / 1ps

module tb_wormhole_round_robin_crossbar_arbiter_top;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4;

  typedef struct packed {
    logic [wrrca_pkg::NUM_OUTPUTS-1:0] consumed;
    logic [wrrca_pkg::NUM_INPUTS-1:0]  eop;
    logic [wrrca_pkg::NUM_INPUTS-1:0]  valid;
  } request_t;

  typedef struct packed {
    logic [wrrca_pkg::CNT_W-1:0]                          active;
    logic [wrrca_pkg::NUM_OUTPUTS-1:0]                    busy;
    logic [wrrca_pkg::NUM_INPUTS-1:0]                     ack;
    logic [wrrca_pkg::NUM_OUTPUTS*wrrca_pkg::IN_IDX_W-1:0] sources;
    logic [wrrca_pkg::NUM_OUTPUTS-1:0]                    mask;
  } grant_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [wrrca_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [wrrca_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic                             cfg_data_i = 1'b0;

  request_t request_q[$];
  grant_t   grant_q[$];
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  int       mismatches = 0;
  int       stall_cycles = 0;

  // arbiter state
  logic                              worm_en = 1'b0;
  logic [wrrca_pkg::NUM_OUTPUTS-1:0] out_busy = '0;
  wrrca_pkg::in_idx_t                out_src [wrrca_pkg::NUM_OUTPUTS];
  logic [wrrca_pkg::NUM_INPUTS-1:0]  in_seen = '0;
  logic [wrrca_pkg::NUM_INPUTS-1:0]  resv_held = '0;
  wrrca_pkg::port_t                  resv_port [wrrca_pkg::NUM_INPUTS];
  logic [wrrca_pkg::NUM_OUTPUTS-1:0] out_resv = '0;
  int                                last_grant = wrrca_pkg::NUM_INPUTS - 1;
  int                                xfer_cnt = 0;

  wormhole_round_robin_crossbar_arbiter_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic grant_t arbitrate(request_t r);
    grant_t g;
    int     i;
    int     j;
    int     cur;
    int     ocur;
    int     dst;
    g = '0;
    for (j = 0; j < wrrca_pkg::NUM_OUTPUTS; j++) begin
      if (out_busy[j] && r.consumed[j]) begin
        g.ack[out_src[j]] = 1'b1;
        in_seen[out_src[j]] = 1'b0;
        out_busy[j] = 1'b0;
        if (xfer_cnt > 0) xfer_cnt--;
      end
    end
    if (xfer_cnt < wrrca_pkg::NUM_OUTPUTS) begin
      cur = last_grant;
      ocur = 0;
      for (i = 0; i < wrrca_pkg::NUM_INPUTS; i++) begin
        cur = (cur == wrrca_pkg::NUM_INPUTS - 1) ? 0 : cur + 1;
        if (r.valid[cur] && !in_seen[cur]) begin
          if (worm_en && resv_held[cur]) begin
            dst = resv_port[cur];
          end else begin
            while (ocur < wrrca_pkg::NUM_OUTPUTS &&
                   (out_busy[ocur] || (worm_en && out_resv[ocur])))
              ocur++;
            dst = ocur;
          end
          if (dst < wrrca_pkg::NUM_OUTPUTS && !out_busy[dst]) begin
            g.mask[dst] = 1'b1;
            g.sources[dst*wrrca_pkg::IN_IDX_W +: wrrca_pkg::IN_IDX_W] =
              wrrca_pkg::in_idx_t'(cur);
            out_src[dst] = wrrca_pkg::in_idx_t'(cur);
            in_seen[cur] = 1'b1;
            out_busy[dst] = 1'b1;
            last_grant = cur;
            xfer_cnt++;
            if (worm_en) begin
              resv_held[cur] = !r.eop[cur];
              out_resv[dst] = !r.eop[cur];
              if (!r.eop[cur]) resv_port[cur] = wrrca_pkg::port_t'(dst);
            end
          end
        end
      end
    end
    g.busy = out_busy;
    g.active = wrrca_pkg::CNT_W'(xfer_cnt);
    return g;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (request_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tdata  <= {{(wrrca_pkg::IN_DATA_W-wrrca_pkg::IN_FIELDS_W){1'b0}},
                          request_q.pop_front()};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  // monitor: check results, then predict new transfers
  always @(posedge clk_i) begin
    grant_t act;
    grant_t exp_g;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        act = grant_t'(m_axis_tdata[wrrca_pkg::OUT_FIELDS_W-1:0]);
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %0h", $time, act);
          mismatches++;
        end else begin
          exp_g = grant_q.pop_front();
          check_field("grant_mask", exp_g.mask, act.mask);
          check_field("grant_sources", exp_g.sources, act.sources);
          check_field("input_ack", exp_g.ack, act.ack);
          check_field("busy_outputs", exp_g.busy, act.busy);
          check_field("active_count", exp_g.active, act.active);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        grant_q.push_back(arbitrate(
          request_t'(s_axis_tdata[wrrca_pkg::IN_FIELDS_W-1:0])));
      if (cfg_valid_i && cfg_ready_o)
        worm_en = cfg_data_i;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("wormhole_round_robin_crossbar_arbiter_top: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_req(logic [wrrca_pkg::NUM_INPUTS-1:0] valid,
                          logic [wrrca_pkg::NUM_INPUTS-1:0] eop,
                          logic [wrrca_pkg::NUM_OUTPUTS-1:0] consumed);
    request_t r;
    r.valid = valid;
    r.eop = eop;
    r.consumed = consumed;
    request_q.push_back(r);
  endtask

  task automatic push_random(int n);
    logic [wrrca_pkg::NUM_INPUTS-1:0]  valid;
    logic [wrrca_pkg::NUM_INPUTS-1:0]  eop;
    logic [wrrca_pkg::NUM_OUTPUTS-1:0] consumed;
    repeat (n) begin
      case ($urandom_range(9))
        0:       valid = '1;
        1:       valid = wrrca_pkg::NUM_INPUTS'(1)
                         << $urandom_range(wrrca_pkg::NUM_INPUTS - 1);
        default: valid = wrrca_pkg::NUM_INPUTS'($urandom);
      endcase
      // mostly long packets so reservations persist
      if ($urandom_range(3) == 0) eop = wrrca_pkg::NUM_INPUTS'($urandom);
      else eop = wrrca_pkg::NUM_INPUTS'($urandom & $urandom & $urandom);
      consumed = ($urandom_range(4) == 0) ? '1 : wrrca_pkg::NUM_OUTPUTS'($urandom);
      push_req(valid, eop, consumed);
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (request_q.size() > 0 || s_axis_tvalid || grant_q.size() > 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_wormhole(logic v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 15;
    snk_idle_pct = 78;

    write_wormhole(1'b0);
    push_req(8'h00, 8'h00, 4'hF);  // consumed bits on idle outputs
    push_req(8'hFF, 8'hFF, 4'h0);
    push_req(8'hFF, 8'h00, 4'h0);  // all outputs busy
    push_req(8'hFF, 8'h00, 4'hF);
    push_req(8'h00, 8'h00, 4'h5);
    push_req(8'hAA, 8'h55, 4'hA);
    push_req(8'hFF, 8'hFF, 4'hF);
    push_req(8'h00, 8'h00, 4'hF);
    drain();

    write_wormhole(1'b1);
    push_req(8'h01, 8'h00, 4'h0);  // input 0 reserves output 0
    push_req(8'h02, 8'h00, 4'h0);
    push_req(8'h03, 8'h00, 4'h1);  // reserved output reused
    push_req(8'h04, 8'h04, 4'h0);
    push_req(8'h78, 8'h00, 4'h4);  // free outputs run out
    push_req(8'hFF, 8'h00, 4'hF);
    push_req(8'hFF, 8'h00, 4'hF);
    push_req(8'hFF, 8'hFF, 4'hF);  // packets end, reservations drop
    push_req(8'hFF, 8'hFF, 4'hF);
    push_req(8'h00, 8'h00, 4'hF);
    drain();

    push_random(267);
    drain();

    write_wormhole(1'b0);  // reservations kept but ignored
    src_idle_pct = 78;
    snk_idle_pct = 15;
    push_random(267);
    drain();

    write_wormhole(1'b1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    push_random(267);
    drain();

    if (mismatches == 0) begin
      $display("wormhole_round_robin_crossbar_arbiter_top: match");
    end else begin
      $display("wormhole_round_robin_crossbar_arbiter_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== wormhole_round_robin_crossbar_arbiter_top.f =====
sv/wrrca_pkg.sv
sv/wrrca_lane.sv
sv/wrrca_merge.sv
sv/wormhole_round_robin_crossbar_arbiter_top.sv
tb/sv/tb_wormhole_round_robin_crossbar_arbiter_top.sv
